### design/frsa_pkg.sv
// Package: request and response word types and code constants for the slot allocator.
package frsa_pkg;

    // Handles on the ports are eight bits wide.
    localparam int HANDLE_W     = 8;
    localparam int HANDLE_SPACE = 2 ** HANDLE_W;

    // Request function codes.
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_TRY     = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_NOT_HELD = 2'd2;

    typedef struct packed {
        logic [1:0]          func;
        logic [HANDLE_W-1:0] slot_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] slot_out;
        logic [1:0]          status;
    } rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

endpackage

### design/frsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write on enable; hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/fifo_recycling_slot_allocator.sv
// A request's result word is registered in the write-back state after it is accepted.
// No new request is taken until the last has written back. Each request reads the held
// map and the release queue when accepted and writes back in the write-back state,
// through one port per memory. A stalled output holds the request in the write-back
// state until the result is taken. Reset: asynchronous, active low; then req_stall stays
// high while the held map, min(SLOTS, 256) entries, is cleared one entry per cycle.
module fifo_recycling_slot_allocator #(
    parameter int SLOTS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  frsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output frsa_pkg::rsp_t rsp
);

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int HELD_DEPTH = (SLOTS < frsa_pkg::HANDLE_SPACE) ? SLOTS
                                                                 : frsa_pkg::HANDLE_SPACE;
    localparam int HELD_W     = $clog2(HELD_DEPTH);

    frsa_pkg::state_t state_reg, state_next;
    logic [HELD_W-1:0] clr_reg, clr_next;
    logic [1:0]        func_reg;
    logic [7:0]        slot_reg;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    logic              rsp_valid_reg;
    frsa_pkg::rsp_t    rsp_reg, rsp_next;

    logic accept;
    logic exec_go;
    logic clearing;

    logic              held_we;
    logic [HELD_W-1:0] held_waddr;
    logic              held_wdata;
    logic              held_rd;
    logic              q_we;
    logic [SLOT_W-1:0] q_rd;

    logic              ex_held_we;
    logic [HELD_W-1:0] ex_held_addr;
    logic              ex_held_data;
    logic [SLOT_W-1:0] grant;
    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W-1:0] tail_inc;
    logic [SLOT_W+7:0] rel_ext;
    logic [SLOT_W+7:0] grant_ext;
    logic              rel_in_range;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frsa_pkg::S_CLEAR:
            begin
                if (clr_reg == HELD_W'(HELD_DEPTH - 1))
                begin
                    state_next = frsa_pkg::S_IDLE;
                end
            end
            frsa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = frsa_pkg::S_EXEC;
                end
            end
            frsa_pkg::S_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = frsa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = frsa_pkg::S_CLEAR;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req_stall = (state_reg != frsa_pkg::S_IDLE);
        clearing  = (state_reg == frsa_pkg::S_CLEAR);
        exec_go   = (state_reg == frsa_pkg::S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    end

    assign accept   = req_valid && !req_stall;
    assign clr_next = clr_reg + 1'b1;

    // Pointer wrap and handle resizing
    assign head_inc     = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc     = (tail_reg == SLOT_W'(SLOTS - 1)) ? '0 : tail_reg + 1'b1;
    assign rel_ext      = {{SLOT_W{1'b0}}, slot_reg};
    assign grant_ext    = {8'd0, grant};
    assign rel_in_range = (32'(slot_reg) < SLOTS);

    // Execute one request from the read data
    always_comb
    begin
        grant        = '0;
        rsp_next     = '0;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        ex_held_we   = 1'b0;
        ex_held_addr = slot_reg[HELD_W-1:0];
        ex_held_data = 1'b0;
        q_we         = 1'b0;
        rsp_next.status = frsa_pkg::ST_OK;
        unique case (func_reg)
            frsa_pkg::FUNC_ALLOC, frsa_pkg::FUNC_TRY:
            begin
                if (count_reg != '0)
                begin
                    // reuse the oldest released slot
                    grant        = q_rd;
                    head_next    = head_inc;
                    count_next   = count_reg - 1'b1;
                    ex_held_we   = 1'b1;
                    ex_held_addr = q_rd[HELD_W-1:0];
                    ex_held_data = 1'b1;
                end
                else if (func_reg == frsa_pkg::FUNC_ALLOC && fresh_reg != CNT_W'(SLOTS))
                begin
                    // take a never-used slot; only releasable handles get a map bit
                    grant        = fresh_reg[SLOT_W-1:0];
                    fresh_next   = fresh_reg + 1'b1;
                    ex_held_we   = (fresh_reg < CNT_W'(HELD_DEPTH));
                    ex_held_addr = fresh_reg[HELD_W-1:0];
                    ex_held_data = 1'b1;
                end
                else
                begin
                    rsp_next.status = frsa_pkg::ST_NONE;
                end
            end
            frsa_pkg::FUNC_RELEASE:
            begin
                if (rel_in_range && held_rd && count_reg != CNT_W'(SLOTS))
                begin
                    // clear the held bit and queue the slot
                    ex_held_we = 1'b1;
                    q_we       = 1'b1;
                    tail_next  = tail_inc;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    rsp_next.status = frsa_pkg::ST_NOT_HELD;
                end
            end
            default:
            begin
                rsp_next.status = frsa_pkg::ST_OK;
            end
        endcase
        rsp_next.slot_out = grant_ext[7:0];
    end

    // Held map write port: clearing pass or write-back
    always_comb
    begin
        if (clearing)
        begin
            held_we    = 1'b1;
            held_waddr = clr_reg;
            held_wdata = 1'b0;
        end
        else
        begin
            held_we    = exec_go && ex_held_we;
            held_waddr = ex_held_addr;
            held_wdata = ex_held_data;
        end
    end

    frsa_ram #(
        .WIDTH (1),
        .DEPTH (HELD_DEPTH)
    ) u_held (
        .clk     (clk),
        .wr_en   (held_we),
        .wr_addr (held_waddr),
        .wr_data (held_wdata),
        .rd_en   (accept),
        .rd_addr (req.slot_in[HELD_W-1:0]),
        .rd_data (held_rd)
    );

    frsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_queue (
        .clk     (clk),
        .wr_en   (exec_go && q_we),
        .wr_addr (tail_reg),
        .wr_data (rel_ext[SLOT_W-1:0]),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (q_rd)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frsa_pkg::S_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_next;
            end
            if (exec_go)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                fresh_reg <= fresh_next;
            end
            // load on write-back, drop once taken
            if (exec_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= req.func;
            slot_reg <= req.slot_in;
        end
        if (exec_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("release queue count exceeds pool size");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CNT_W'(SLOTS))
        else $error("fresh counter exceeds pool size");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == frsa_pkg::S_EXEC))
        else $error("accepted request did not enter write-back");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != frsa_pkg::ST_OK) |-> (rsp_reg.slot_out == '0))
        else $error("failed request returned a nonzero handle");
`endif

endmodule

### tb/fifo_recycling_slot_allocator_test.sv
// Testbench for the slot allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module fifo_recycling_slot_allocator_test;

    localparam int SLOTS = 256;
    // Selector with no function: the block answers with an empty ok word.
    localparam logic [1:0] FUNC_NOP = 2'd3;
    // Cycles with no handshake on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 200;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 10;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    frsa_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    frsa_pkg::rsp_t rsp;

    // Predicted allocator state.
    logic [SLOTS-1:0] held_model;
    logic [7:0]       recycle_fifo [SLOTS];
    logic [7:0]       fifo_rd;
    logic [7:0]       fifo_wr;
    int               fifo_level;
    int               fresh_ptr;

    // Response words still owed by the block, oldest first.
    frsa_pkg::rsp_t rsp_expected [$];
    frsa_pkg::rsp_t rsp_want;
    int             mismatch_count;
    int             rsp_seen;
    bit             idle_on;
    int             long_hold_cycles;

    fifo_recycling_slot_allocator #(
        .SLOTS (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Generate the clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Compute the response to one request and advance the predicted state.
    function automatic frsa_pkg::rsp_t predict_rsp(input frsa_pkg::req_t word);
        frsa_pkg::rsp_t r;
        r.slot_out = '0;
        r.status   = frsa_pkg::ST_OK;
        case (word.func)
            frsa_pkg::FUNC_ALLOC, frsa_pkg::FUNC_TRY:
            begin
                if (fifo_level != 0)
                begin
                    r.slot_out = recycle_fifo[fifo_rd];
                    fifo_rd    = fifo_rd + 8'd1;
                    fifo_level = fifo_level - 1;
                    held_model[r.slot_out] = 1'b1;
                end
                else if (word.func == frsa_pkg::FUNC_ALLOC && fresh_ptr < SLOTS)
                begin
                    r.slot_out = fresh_ptr[7:0];
                    held_model[r.slot_out] = 1'b1;
                    fresh_ptr  = fresh_ptr + 1;
                end
                else
                    r.status = frsa_pkg::ST_NONE;
            end
            frsa_pkg::FUNC_RELEASE:
            begin
                if (held_model[word.slot_in] && fifo_level < SLOTS)
                begin
                    held_model[word.slot_in] = 1'b0;
                    recycle_fifo[fifo_wr]    = word.slot_in;
                    fifo_wr    = fifo_wr + 8'd1;
                    fifo_level = fifo_level + 1;
                end
                else
                    r.status = frsa_pkg::ST_NOT_HELD;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Find a held slot from a random starting point; any slot if none is held.
    function automatic logic [7:0] pick_held_slot();
        logic [7:0] start;
        logic [7:0] probe;
        start = 8'($urandom_range(0, 255));
        for (int k = 0; k < SLOTS; k++)
        begin
            probe = start + 8'(k);
            if (held_model[probe])
                return probe;
        end
        return start;
    endfunction

    // Offer one request word, hold it until accepted, then record its response.
    task automatic send_req(input logic [1:0] func, input logic [7:0] slot);
        int             gap;
        frsa_pkg::req_t word;
        word.func    = func;
        word.slot_in = slot;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        rsp_expected.push_back(predict_rsp(word));
    endtask

    // Mostly well-formed traffic, with some bad releases and unused selectors.
    task automatic send_random_req();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_req(frsa_pkg::FUNC_ALLOC, 8'($urandom_range(0, 255)));
        else if (pick < 50)
            send_req(frsa_pkg::FUNC_TRY, 8'($urandom_range(0, 255)));
        else if (pick < 85)
            send_req(frsa_pkg::FUNC_RELEASE, pick_held_slot());
        else if (pick < 95)
            send_req(frsa_pkg::FUNC_RELEASE, 8'($urandom_range(0, 255)));
        else
            send_req(FUNC_NOP, 8'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait until every owed response has arrived.
    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        send_req(frsa_pkg::FUNC_TRY, 8'h00);        // nothing released yet
        send_req(frsa_pkg::FUNC_RELEASE, 8'h00);    // never granted
        send_req(FUNC_NOP, 8'hFF);
        send_req(frsa_pkg::FUNC_ALLOC, 8'hFF);      // fresh slot 0
        send_req(frsa_pkg::FUNC_ALLOC, 8'h00);
        send_req(frsa_pkg::FUNC_ALLOC, 8'h5A);
        send_req(frsa_pkg::FUNC_RELEASE, 8'h01);
        send_req(frsa_pkg::FUNC_RELEASE, 8'h01);    // already released
        send_req(frsa_pkg::FUNC_RELEASE, 8'hFF);    // never granted, top handle
        send_req(frsa_pkg::FUNC_RELEASE, 8'h00);
        send_req(frsa_pkg::FUNC_TRY, 8'hA5);        // oldest released first
        send_req(frsa_pkg::FUNC_ALLOC, 8'h33);      // reuse before fresh
        send_req(frsa_pkg::FUNC_ALLOC, 8'hCC);      // fresh again
        send_req(frsa_pkg::FUNC_RELEASE, 8'h02);
        send_req(frsa_pkg::FUNC_RELEASE, 8'h03);
        send_req(FUNC_NOP, 8'hAA);
        send_req(frsa_pkg::FUNC_TRY, 8'h55);
        send_req(frsa_pkg::FUNC_TRY, 8'h0F);
        send_req(frsa_pkg::FUNC_TRY, 8'hF0);        // queue empty again
        send_req(frsa_pkg::FUNC_RELEASE, 8'h04);    // beyond fresh pointer
    endtask

    // Take every fresh slot, then ask for more.
    task automatic test_pool_exhaustion();
        while (fresh_ptr < SLOTS || fifo_level != 0)
            send_req(frsa_pkg::FUNC_ALLOC, 8'($urandom_range(0, 255)));
        send_req(frsa_pkg::FUNC_ALLOC, 8'h00);
        send_req(frsa_pkg::FUNC_ALLOC, 8'hFF);
        send_req(frsa_pkg::FUNC_TRY, 8'h80);
    endtask

    // Release every slot in shuffled order so the queue fills completely.
    task automatic test_release_all();
        logic [7:0] order [SLOTS];
        logic [7:0] tmp;
        int         j;
        for (int k = 0; k < SLOTS; k++)
            order[k] = 8'(k);
        for (int k = SLOTS - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < SLOTS; k++)
            send_req(frsa_pkg::FUNC_RELEASE, order[k]);
        send_req(frsa_pkg::FUNC_RELEASE, order[0]);
        send_req(frsa_pkg::FUNC_TRY, 8'h00);
        send_req(frsa_pkg::FUNC_ALLOC, 8'hFF);
    endtask

    task automatic test_random_mix();
        repeat (40) send_random_req();
    endtask

    // Hold the response side for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        long_hold_cycles = LONG_HOLD;
        repeat (16) send_random_req();
        while (long_hold_cycles != 0)
            @(posedge clk);
    endtask

    // Pause the request side until the block has answered everything.
    task automatic test_drain_pause();
        repeat (16) send_random_req();
        wait_for_results();
        repeat (16) send_random_req();
    endtask

    // No idling anywhere: back-to-back words on both sides.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (40) send_random_req();
    endtask

    // Log one mismatch; only the first few are printed.
    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("rsp word %0d: %s", rsp_seen, what);
    endtask

    // Check each accepted response word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (rsp_expected.size() == 0)
                log_mismatch($sformatf("unexpected word, slot_out %0d status %0d",
                                       rsp.slot_out, rsp.status));
            else
            begin
                rsp_want = rsp_expected.pop_front();
                if (rsp.slot_out !== rsp_want.slot_out)
                    log_mismatch($sformatf("slot_out expected %0d, got %0d",
                                           rsp_want.slot_out, rsp.slot_out));
                if (rsp.status !== rsp_want.status)
                    log_mismatch($sformatf("status expected %0d, got %0d",
                                           rsp_want.status, rsp.status));
            end
            rsp_seen++;
        end
    end

    // Drive the response stall: long hold on request, random bursts otherwise.
    initial
    begin : rsp_stall_driver
        int burst;
        forever
        begin
            @(negedge clk);
            if (long_hold_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (long_hold_cycles - 1) @(negedge clk);
                long_hold_cycles = 0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 12);
                rsp_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Abandon the run when neither side moves a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid === 1'b1 && req_stall === 1'b0) ||
                (rsp_valid === 1'b1 && rsp_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("fifo_recycling_slot_allocator: mismatch");
        $finish;
    end

    // Reset, run every test in turn, drain, and report.
    initial
    begin
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req              = '0;
        rsp_stall        = 1'b0;
        held_model       = '0;
        fifo_rd          = '0;
        fifo_wr          = '0;
        fifo_level       = 0;
        fresh_ptr        = 0;
        mismatch_count   = 0;
        rsp_seen         = 0;
        idle_on          = 1'b1;
        long_hold_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_pool_exhaustion();
        test_release_all();
        test_random_mix();
        test_output_backpressure();
        test_drain_pause();
        test_back_to_back();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && rsp_expected.size() == 0)
            $display("fifo_recycling_slot_allocator: match");
        else
            $display("fifo_recycling_slot_allocator: mismatch");
        $finish;
    end

endmodule
